/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define BPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define BPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* src/bpe_pkg.sv */
package bpe_pkg;

  localparam int unsigned MAX_POINTS_DEF = 16;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned T_W      = 17;
  localparam int unsigned STATUS_W = 2;

  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd2;

  // broadcast to every cell
  typedef struct packed {
    logic           copy;  // working point <= stored point
    logic           step;  // one de Casteljau round
    logic [T_W-1:0] t;     // saturated parameter
  } cell_cmd_t;

endpackage

/* src/bpe_cell.sv */
module bpe_cell (
  input  logic                                  clk_i,
  input  logic                                  load_en_i,
  input  logic signed [bpe_pkg::COORD_W-1:0]    load_x_i,
  input  logic signed [bpe_pkg::COORD_W-1:0]    load_y_i,
  input  bpe_pkg::cell_cmd_t                    cmd_i,
  input  logic signed [bpe_pkg::COORD_W-1:0]    nb_x_i,
  input  logic signed [bpe_pkg::COORD_W-1:0]    nb_y_i,
  output logic signed [bpe_pkg::COORD_W-1:0]    work_x_o,
  output logic signed [bpe_pkg::COORD_W-1:0]    work_y_o
);

  logic signed [bpe_pkg::COORD_W-1:0] stored_x_q, stored_y_q;
  logic signed [bpe_pkg::COORD_W-1:0] work_x_q, work_x_d;
  logic signed [bpe_pkg::COORD_W-1:0] work_y_q, work_y_d;

  // a + floor(t * (b - a) / 2^16); result stays between a and b
  function automatic logic signed [15:0] lerp_q16(
    input logic signed [15:0] a,
    input logic signed [15:0] b,
    input logic        [16:0] t
  );
    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [18:0] sum;
    diff = {b[15], b} - {a[15], a};
    prod = $signed({18'b0, t}) * $signed({{18{diff[16]}}, diff});
    sum  = prod[34:16] + {{3{a[15]}}, a};
    return sum[15:0];
  endfunction

  always_comb begin
    work_x_d = work_x_q;
    work_y_d = work_y_q;
    if (cmd_i.copy) begin
      work_x_d = stored_x_q;
      work_y_d = stored_y_q;
    end else if (cmd_i.step) begin
      work_x_d = lerp_q16(work_x_q, nb_x_i, cmd_i.t);
      work_y_d = lerp_q16(work_y_q, nb_y_i, cmd_i.t);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      stored_x_q <= load_x_i;
      stored_y_q <= load_y_i;
    end
    work_x_q <= work_x_d;
    work_y_q <= work_y_d;
  end

  assign work_x_o = work_x_q;
  assign work_y_o = work_y_q;

endmodule

/* src/bezier_point_evaluator.sv */
// Channel | Handshake                  | Fields
// --------+----------------------------+-------------------------------------------
// request | in_valid_i / in_stall_o    | opcode, start_curve, point_x/y, t_param
// result  | out_valid_o / out_stall_i  | curve_x, curve_y, status
//
// A load gives no result. An evaluate over N stored points runs in the
// cell row as one copy, then N - 1 de Casteljau rounds of the cell chain,
// one per cycle, then the write of the output register. The request side
// stalls from an accepted evaluate until its result is in the output
// register. A stalled result holds the output register and keeps the
// next result waiting in the cell row. Reset clears count, dropped flag,
// sequencer and output valid; stored points are unknown.
module bezier_point_evaluator #(
  parameter int unsigned MaxPoints = bpe_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  opcode_i,
  input  logic                                  start_curve_i,
  input  logic signed [bpe_pkg::COORD_W-1:0]    point_x_i,
  input  logic signed [bpe_pkg::COORD_W-1:0]    point_y_i,
  input  logic        [bpe_pkg::T_W-1:0]        t_param_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bpe_pkg::COORD_W-1:0]    curve_x_o,
  output logic signed [bpe_pkg::COORD_W-1:0]    curve_y_o,
  output logic        [bpe_pkg::STATUS_W-1:0]   status_o
);

  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPoints);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  state_e                        state_q;
  logic [CntW-1:0]               count_q;
  logic                          dropped_q;
  logic [CntW-1:0]               rounds_q;
  logic [bpe_pkg::T_W-1:0]       t_q;
  logic                          out_valid_q;
  logic signed [bpe_pkg::COORD_W-1:0] out_x_q, out_y_q;
  logic [bpe_pkg::STATUS_W-1:0]  out_status_q;

  logic in_acc, is_load, is_eval, out_free, finish;
  logic [bpe_pkg::T_W-1:0] t_sat;
  bpe_pkg::cell_cmd_t cmd;

  logic signed [bpe_pkg::COORD_W-1:0] wx [MaxPoints];
  logic signed [bpe_pkg::COORD_W-1:0] wy [MaxPoints];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_load    = in_acc && (opcode_i == bpe_pkg::OP_LOAD);
  assign is_eval    = in_acc && (opcode_i == bpe_pkg::OP_EVAL);

  // t above 1.0 saturates
  assign t_sat = (t_param_i > bpe_pkg::T_ONE) ? bpe_pkg::T_ONE : t_param_i;

  // output register is free if empty or being taken this edge
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == S_RUN) && (rounds_q == '0) && out_free;

  assign cmd.copy = is_eval;
  assign cmd.step = (state_q == S_RUN) && (rounds_q != '0);
  assign cmd.t    = t_q;

  // Row of cells; cell i lerps toward cell i+1. The last cell's
  // neighbor is itself, its result is never used past round zero.
  for (genvar i = 0; i < MaxPoints; i++) begin : g_cell
    logic load_en;
    logic signed [bpe_pkg::COORD_W-1:0] nb_x, nb_y;

    // start_curve writes cell 0, otherwise append at the fill count
    assign load_en = is_load &&
                     (start_curve_i ? (i == 0) : (count_q == CntW'(i)));

    if (i + 1 < MaxPoints) begin : g_nb
      assign nb_x = wx[i+1];
      assign nb_y = wy[i+1];
    end else begin : g_last
      assign nb_x = wx[i];
      assign nb_y = wy[i];
    end

    bpe_cell u_cell (
      .clk_i     (clk_i),
      .load_en_i (load_en),
      .load_x_i  (point_x_i),
      .load_y_i  (point_y_i),
      .cmd_i     (cmd),
      .nb_x_i    (nb_x),
      .nb_y_i    (nb_y),
      .work_x_o  (wx[i]),
      .work_y_o  (wy[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      dropped_q    <= 1'b0;
      rounds_q     <= '0;
      t_q          <= '0;
      out_valid_q  <= 1'b0;
      out_x_q      <= '0;
      out_y_q      <= '0;
      out_status_q <= bpe_pkg::ST_OK;
    end else begin
      // a result taken in the finishing cycle is replaced below
      if (out_valid_q && !out_stall_i && !finish) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (is_load) begin
            if (start_curve_i) begin
              count_q   <= CntW'(1);
              dropped_q <= 1'b0;
            end else if (count_q < CntMax) begin
              count_q <= count_q + CntW'(1);
            end else begin
              dropped_q <= 1'b1;
            end
          end else if (is_eval) begin
            t_q      <= t_sat;
            rounds_q <= (count_q == '0) ? '0 : count_q - CntW'(1);
            state_q  <= S_RUN;
          end
        end
        S_RUN: begin
          if (rounds_q != '0) begin
            rounds_q <= rounds_q - CntW'(1);
          end else if (finish) begin
            out_valid_q <= 1'b1;
            if (count_q == '0) begin
              out_x_q      <= '0;
              out_y_q      <= '0;
              out_status_q <= bpe_pkg::ST_EMPTY;
            end else begin
              out_x_q      <= wx[0];
              out_y_q      <= wy[0];
              out_status_q <= dropped_q ? bpe_pkg::ST_DROPPED : bpe_pkg::ST_OK;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign curve_x_o   = out_x_q;
  assign curve_y_o   = out_y_q;
  assign status_o    = out_status_q;

endmodule

/* src/bpe_checker.sv */
`include "assert_macros.svh"

module bpe_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  opcode_i,
  input logic                                  start_curve_i,
  input logic signed [bpe_pkg::COORD_W-1:0]    point_x_i,
  input logic signed [bpe_pkg::COORD_W-1:0]    point_y_i,
  input logic        [bpe_pkg::T_W-1:0]        t_param_i,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [bpe_pkg::COORD_W-1:0]    curve_x_o,
  input logic signed [bpe_pkg::COORD_W-1:0]    curve_y_o,
  input logic        [bpe_pkg::STATUS_W-1:0]   status_o
);

  // an evaluate request blocks the request side on the next cycle
  `BPE_ASSERT(a_eval_stalls, clk_i, rst_ni, in_valid_i && !in_stall_o && opcode_i == bpe_pkg::OP_EVAL |=> in_stall_o, "evaluate did not stall requests")

  // empty store gives the origin
  `BPE_ASSERT(a_empty_zero, clk_i, rst_ni, out_valid_o && status_o == bpe_pkg::ST_EMPTY |-> curve_x_o == '0 && curve_y_o == '0, "empty result not zero")

  // a held result keeps its payload
  `BPE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(curve_x_o) && $stable(curve_y_o) && $stable(status_o), "stalled result changed")

  // no result in the cycle after a reset cycle
  `BPE_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (.*);
